>>> hdl/sdsf_pkg.sv
package sdsf_pkg;

	// Fixed bytes of a data-set frame.
	localparam logic [7:0] SOX_BYTE   = 8'hF0;
	localparam logic [7:0] MAKER_BYTE = 8'h41;
	localparam logic [7:0] DT1_CMD    = 8'h12;
	localparam logic [7:0] EOX_BYTE   = 8'hF7;
	localparam logic [6:0] SEVEN_MASK = 7'h7F;

	// Reset values of the configuration registers.
	localparam logic       ENABLE_RST = 1'b1;
	localparam logic [6:0] DEVICE_RST = 7'd16;
	localparam logic [6:0] MODEL_RST  = 7'd66;

	// Configuration register indexes.
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_DEVICE = 2'd1;
	localparam logic [1:0] REG_MODEL  = 2'd2;

	// Byte positions inside a frame, in emission order.
	localparam logic [3:0] POS_SOX   = 4'd0;
	localparam logic [3:0] POS_MAKER = 4'd1;
	localparam logic [3:0] POS_DEV   = 4'd2;
	localparam logic [3:0] POS_MODEL = 4'd3;
	localparam logic [3:0] POS_CMD   = 4'd4;
	localparam logic [3:0] POS_ADDR1 = 4'd5;
	localparam logic [3:0] POS_ADDR2 = 4'd6;
	localparam logic [3:0] POS_ADDR3 = 4'd7;
	localparam logic [3:0] POS_DATA  = 4'd8;
	localparam logic [3:0] POS_CHK   = 4'd9;
	localparam logic [3:0] POS_EOX   = 4'd10;

	// Command queue between the front and the back.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	typedef struct packed {
		logic       enable;
		logic [6:0] device_id;
		logic [6:0] model_id;
	} cfg_t;

	typedef struct packed {
		logic        first;
		logic        fin;
		logic [6:0]  device_id;
		logic [6:0]  model_id;
		logic [23:0] address;
		logic [7:0]  payload;
		logic [6:0]  checksum;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

>>> hdl/sdsf_front.sv
module sdsf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  sdsf_pkg::cfg_t      cfg,
	input  logic                push,
	input  logic [23:0]         address,
	input  logic [7:0]          payload,
	input  logic                first,
	input  logic                final_req,
	input  sdsf_pkg::fifo_stat_t fifo_stat,
	output logic                full,
	output logic                cmd_push,
	output sdsf_pkg::cmd_t      cmd
);

	logic       in_frame_q;
	logic [6:0] sum_q;
	logic       accept;
	logic       emit;
	logic [6:0] base_sum;
	logic [6:0] sum_n;

	assign full   = fifo_stat.full;
	assign accept = push && !fifo_stat.full;
	// Words that produce no bytes are swallowed here and never queued.
	assign emit   = cfg.enable && (first || in_frame_q);

	always_comb begin
		if (first) begin
			base_sum = address[22:16] + address[14:8] + address[6:0];
		end else begin
			base_sum = sum_q;
		end
		sum_n = base_sum + payload[6:0];
	end

	assign cmd_push      = accept && emit;
	assign cmd.first     = first;
	assign cmd.fin       = final_req;
	assign cmd.device_id = cfg.device_id;
	assign cmd.model_id  = cfg.model_id;
	assign cmd.address   = address;
	assign cmd.payload   = payload;
	assign cmd.checksum  = sum_n ^ sdsf_pkg::SEVEN_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			sum_q      <= 7'd0;
		end else if (cmd_push) begin
			in_frame_q <= !final_req;
			sum_q      <= final_req ? 7'd0 : sum_n;
		end
	end

endmodule

>>> hdl/sdsf_fifo.sv
module sdsf_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  sdsf_pkg::cmd_t       wr_cmd,
	input  logic                 rd_en,
	output sdsf_pkg::cmd_t       head,
	output sdsf_pkg::fifo_stat_t stat
);

	sdsf_pkg::cmd_t                   mem_q [sdsf_pkg::FIFO_DEPTH];
	logic [sdsf_pkg::PTR_W-1:0]       wr_ptr_q;
	logic [sdsf_pkg::PTR_W-1:0]       rd_ptr_q;
	logic [sdsf_pkg::CNT_W-1:0]       cnt_q;
	logic                             do_wr;
	logic                             do_rd;

	assign stat.full  = cnt_q == sdsf_pkg::CNT_W'(sdsf_pkg::FIFO_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + sdsf_pkg::PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + sdsf_pkg::PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + sdsf_pkg::CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - sdsf_pkg::CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/sdsf_back.sv
module sdsf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdsf_pkg::cmd_t       head,
	input  sdsf_pkg::fifo_stat_t fifo_stat,
	output logic                 fifo_pop,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 frame_end
);

	logic       started_q;
	logic [3:0] idx_q;
	logic       out_valid_q;
	logic [3:0] pos;
	logic       last;
	logic       advance;
	logic [7:0] byte_n;

	assign advance = !fifo_stat.empty && (!out_valid_q || pop);

	always_comb begin
		if (started_q) begin
			pos = idx_q;
		end else if (head.first) begin
			pos = sdsf_pkg::POS_SOX;
		end else begin
			pos = sdsf_pkg::POS_DATA;
		end
		last = pos == (head.fin ? sdsf_pkg::POS_EOX : sdsf_pkg::POS_DATA);
		case (pos)
			sdsf_pkg::POS_SOX:   byte_n = sdsf_pkg::SOX_BYTE;
			sdsf_pkg::POS_MAKER: byte_n = sdsf_pkg::MAKER_BYTE;
			sdsf_pkg::POS_DEV:   byte_n = {1'b0, head.device_id};
			sdsf_pkg::POS_MODEL: byte_n = {1'b0, head.model_id};
			sdsf_pkg::POS_CMD:   byte_n = sdsf_pkg::DT1_CMD;
			sdsf_pkg::POS_ADDR1: byte_n = head.address[23:16];
			sdsf_pkg::POS_ADDR2: byte_n = head.address[15:8];
			sdsf_pkg::POS_ADDR3: byte_n = head.address[7:0];
			sdsf_pkg::POS_DATA:  byte_n = head.payload;
			sdsf_pkg::POS_CHK:   byte_n = {1'b0, head.checksum};
			sdsf_pkg::POS_EOX:   byte_n = sdsf_pkg::EOX_BYTE;
			default:             byte_n = sdsf_pkg::EOX_BYTE;
		endcase
	end

	assign fifo_pop = advance && last;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			idx_q       <= sdsf_pkg::POS_SOX;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				started_q   <= !last;
				idx_q       <= pos + 4'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte  <= byte_n;
			run_last  <= last;
			frame_end <= byte_n == sdsf_pkg::EOX_BYTE;
		end
	end

endmodule

>>> hdl/sysex_data_set_framer_core.sv
// System-exclusive data-set framer. Each word pushed in carries one data byte; a word
// with first set opens a frame and brings out the start byte, maker byte, device and
// model identifiers, the data-set command, three address bytes and its data byte
// (nine bytes), a later word brings out its data byte only, and a word with final_req
// set adds the checksum and the end byte. Words are taken one per cycle while the
// four-entry command queue has room; the result side delivers one byte per cycle while
// pop is held, and a word produces one, three, nine or eleven bytes, which the byte
// sequencer in the back end walks through in order. Words that arrive while the
// block is disabled, or with no frame open, are dropped at the front and produce
// nothing. run_last marks the last byte of each word and frame_end marks every byte
// equal to the end byte. Configuration is written through cfg_valid/cfg_ready, which
// is always ready; it should only change while no frame is in progress.
module sysex_data_set_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [23:0] address,
	input  logic [7:0]  payload,
	input  logic        first,
	input  logic        final_req,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	sdsf_pkg::cfg_t       cfg_q;
	sdsf_pkg::cmd_t       front_cmd;
	sdsf_pkg::cmd_t       head_cmd;
	sdsf_pkg::fifo_stat_t fifo_stat;
	logic                 cmd_push;
	logic                 cmd_pop;

	// Configuration registers. Writes to an index past the list are accepted and ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= sdsf_pkg::ENABLE_RST;
			cfg_q.device_id <= sdsf_pkg::DEVICE_RST;
			cfg_q.model_id  <= sdsf_pkg::MODEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sdsf_pkg::REG_ENABLE: cfg_q.enable    <= cfg_data[0];
				sdsf_pkg::REG_DEVICE: cfg_q.device_id <= cfg_data;
				sdsf_pkg::REG_MODEL:  cfg_q.model_id  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end tracks the open frame and the running checksum, and queues one
	// command per word that produces bytes, with the identifiers captured alongside.
	sdsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.address   (address),
		.payload   (payload),
		.first     (first),
		.final_req (final_req),
		.fifo_stat (fifo_stat),
		.full      (full),
		.cmd_push  (cmd_push),
		.cmd       (front_cmd)
	);

	sdsf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (front_cmd),
		.rd_en  (cmd_pop),
		.head   (head_cmd),
		.stat   (fifo_stat)
	);

	// The back end walks the byte positions of the head command into the output
	// register and releases the command after its last byte.
	sdsf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_cmd),
		.fifo_stat (fifo_stat),
		.fifo_pop  (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

	// A byte flagged as an end byte always carries the end byte value. Payload and
	// address bytes may equal it too, so the flag says nothing about run_last.
	a_eox_value: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> (out_byte == sdsf_pkg::EOX_BYTE))
		else $error("end byte flag on a byte of another value");

	// Nothing is queued while the block is disabled.
	a_no_cmd_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> cfg_q.enable)
		else $error("command queued while disabled");

	// The queue never reports full and empty together.
	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
		else $error("command queue full and empty at once");

endmodule
